// File: hdl/srctok_pkg.sv
// ----------------------------------------------------------------------------
// srctok_pkg
// Types, constants and keyword table shared by the source tokenizer files.
// ----------------------------------------------------------------------------
package srctok_pkg;

   // Position counter and run length widths
   localparam int PositionBits = 32;
   localparam int LengthBits   = 16;

   // Fixed widths of the result fields
   localparam int TokKindW  = 5;
   localparam int TokStartW = 32;
   localparam int TokLenW   = 16;
   localparam int TokLineW  = 32;
   localparam int ByteW     = 8;

   // Longest keyword in bytes, and width of the keyword buffer
   localparam int KwMaxLen = 6;
   localparam int KwBufW   = KwMaxLen * ByteW;
   localparam int KwCount  = 10;
   localparam int KwLenW   = 3;

   // Queue between front and back; depth must be a power of two
   localparam int QueueDepth = 4;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCountW    = $clog2(QueueDepth + 1);

   localparam logic [LengthBits-1:0] LenMax = '1;

   // Input item kinds
   localparam logic ItemByte = 1'b0;
   localparam logic ItemEnd  = 1'b1;

   // Character codes
   localparam logic [ByteW-1:0] ChPlus   = 8'h2B;
   localparam logic [ByteW-1:0] ChMinus  = 8'h2D;
   localparam logic [ByteW-1:0] ChStar   = 8'h2A;
   localparam logic [ByteW-1:0] ChSlash  = 8'h2F;
   localparam logic [ByteW-1:0] ChLess   = 8'h3C;
   localparam logic [ByteW-1:0] ChLParen = 8'h28;
   localparam logic [ByteW-1:0] ChRParen = 8'h29;
   localparam logic [ByteW-1:0] ChLBrace = 8'h7B;
   localparam logic [ByteW-1:0] ChRBrace = 8'h7D;
   localparam logic [ByteW-1:0] ChComma  = 8'h2C;
   localparam logic [ByteW-1:0] ChEqual  = 8'h3D;
   localparam logic [ByteW-1:0] ChSpace  = 8'h20;
   localparam logic [ByteW-1:0] ChTab    = 8'h09;
   localparam logic [ByteW-1:0] ChCr     = 8'h0D;
   localparam logic [ByteW-1:0] ChLf     = 8'h0A;
   localparam logic [ByteW-1:0] ChDigit0 = 8'h30;
   localparam logic [ByteW-1:0] ChDigit9 = 8'h39;
   localparam logic [ByteW-1:0] ChLowerA = 8'h61;
   localparam logic [ByteW-1:0] ChLowerZ = 8'h7A;
   localparam logic [ByteW-1:0] ChUpperA = 8'h41;
   localparam logic [ByteW-1:0] ChUpperZ = 8'h5A;

   typedef enum logic [TokKindW-1:0] {
      TK_PLUS        = 5'd0,
      TK_MINUS       = 5'd1,
      TK_STAR        = 5'd2,
      TK_SLASH       = 5'd3,
      TK_LESS        = 5'd4,
      TK_LPAREN      = 5'd5,
      TK_RPAREN      = 5'd6,
      TK_LBRACE      = 5'd7,
      TK_RBRACE      = 5'd8,
      TK_COMMA       = 5'd9,
      TK_EQUAL       = 5'd10,
      TK_EQUAL_EQUAL = 5'd11,
      TK_NUMBER      = 5'd12,
      TK_IDENT       = 5'd13,
      TK_LET         = 5'd14,
      TK_IF          = 5'd15,
      TK_ELSE        = 5'd16,
      TK_WHILE       = 5'd17,
      TK_PRINT       = 5'd18,
      TK_INPUT       = 5'd19,
      TK_BOOLEAN     = 5'd20,
      TK_DEF         = 5'd21,
      TK_RETURN      = 5'd22,
      TK_ERROR       = 5'd23,
      TK_EOF         = 5'd24
   } tok_kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_NUM  = 2'd1,
      MODE_ID   = 2'd2,
      MODE_EQ   = 2'd3
   } scan_mode_type;

   typedef struct packed {
      tok_kind_type           kind;
      logic [TokStartW-1:0]   start;
      logic [TokLenW-1:0]     length;
      logic [TokLineW-1:0]    line;
      logic                   bool_value;
      logic [ByteW-1:0]       error_byte;
   } tok_slot_type;

   // One queue entry holds every token caused by one input item
   typedef struct packed {
      tok_slot_type first;
      tok_slot_type second;
      logic         two;
   } q_entry_type;

   typedef struct packed {
      logic        push;
      q_entry_type entry;
   } q_wr_type;

   typedef struct packed {
      logic        valid;
      q_entry_type entry;
   } q_rd_type;

   typedef struct packed {
      tok_kind_type kind;
      logic         bool_value;
   } kw_hit_type;

   // Keyword texts, first byte in the low bits
   localparam logic [KwBufW-1:0] KwText [KwCount] = '{
      48'h00000074656C,   // let
      48'h000000006669,   // if
      48'h000065736C65,   // else
      48'h00656C696877,   // while
      48'h00746E697270,   // print
      48'h007475706E69,   // input
      48'h000065757274,   // true
      48'h0065736C6166,   // false
      48'h000000666564,   // def
      48'h6E7275746572    // return
   };
   localparam logic [KwLenW-1:0] KwLen [KwCount] = '{
      3'd3, 3'd2, 3'd4, 3'd5, 3'd5, 3'd5, 3'd4, 3'd5, 3'd3, 3'd6
   };
   localparam tok_kind_type KwKind [KwCount] = '{
      TK_LET, TK_IF, TK_ELSE, TK_WHILE, TK_PRINT,
      TK_INPUT, TK_BOOLEAN, TK_BOOLEAN, TK_DEF, TK_RETURN
   };
   localparam int KwTrueIdx = 6;

   function automatic kw_hit_type kw_lookup(input logic [KwBufW-1:0] text,
                                            input logic [LengthBits-1:0] len);
      kw_hit_type hit;
      logic       found;
      hit.kind       = TK_IDENT;
      hit.bool_value = 1'b0;
      found          = 1'b0;
      if (len <= LengthBits'(KwMaxLen) && len < LenMax) begin
         for (int i = 0; i < KwCount; i++) begin
            if (!found && len == LengthBits'(KwLen[i]) && text == KwText[i]) begin
               found          = 1'b1;
               hit.kind       = KwKind[i];
               hit.bool_value = (i == KwTrueIdx);
            end
         end
      end
      return hit;
   endfunction

   function automatic tok_slot_type mk_slot(input tok_kind_type kind,
                                            input logic [PositionBits-1:0] start,
                                            input logic [TokLenW-1:0] length,
                                            input logic [TokLineW-1:0] line,
                                            input logic bool_value,
                                            input logic [ByteW-1:0] error_byte);
      tok_slot_type s;
      s.kind       = kind;
      s.start      = TokStartW'(start);
      s.length     = length;
      s.line       = line;
      s.bool_value = bool_value;
      s.error_byte = error_byte;
      return s;
   endfunction

endpackage

// File: hdl/srctok_req_if.sv
// ----------------------------------------------------------------------------
// srctok_req_if
// Source byte channel: one byte or end marker per word.
// ----------------------------------------------------------------------------
interface srctok_req_if;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [srctok_pkg::ByteW-1:0] byte_value;

   modport source (output valid, kind, byte_value, input ready);
   modport sink   (input valid, kind, byte_value, output ready);
endinterface

// File: hdl/srctok_rsp_if.sv
// ----------------------------------------------------------------------------
// srctok_rsp_if
// Token channel: one token per word.
// ----------------------------------------------------------------------------
interface srctok_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [srctok_pkg::TokKindW-1:0]  token_kind;
   logic [srctok_pkg::TokStartW-1:0] start_pos;
   logic [srctok_pkg::TokLenW-1:0]   token_length;
   logic [srctok_pkg::TokLineW-1:0]  line_number;
   logic                             bool_value;
   logic [srctok_pkg::ByteW-1:0]     error_byte;
   logic                             last;

   modport source (output valid, token_kind, start_pos, token_length, line_number,
                   bool_value, error_byte, last, input ready);
   modport sink   (input valid, token_kind, start_pos, token_length, line_number,
                   bool_value, error_byte, last, output ready);
endinterface

// File: hdl/srctok_front.sv
// ----------------------------------------------------------------------------
// srctok_front
// Scanner: classifies each byte, tracks the pending run and builds tokens.
// ----------------------------------------------------------------------------
module srctok_front (
   input  logic                   clock,
   input  logic                   reset,
   srctok_req_if.sink             req_ch,
   input  logic                   q_full,
   output srctok_pkg::q_wr_type   q_wr
);

   srctok_pkg::scan_mode_type                mode_ff, mode_in;
   logic [srctok_pkg::PositionBits-1:0]      pos_ff, pos_in;
   logic [srctok_pkg::PositionBits-1:0]      start_ff, start_in;
   logic [srctok_pkg::LengthBits-1:0]        run_ff, run_in;
   logic [srctok_pkg::KwBufW-1:0]            kbuf_ff, kbuf_in;
   logic [srctok_pkg::TokLineW-1:0]          line_ff, line_in;

   logic                                     accept;
   logic [srctok_pkg::ByteW-1:0]             b;
   logic                                     is_digit, is_alpha, extend;
   srctok_pkg::kw_hit_type                   hit;
   srctok_pkg::tok_slot_type                 flush_tok, byte_tok;
   logic                                     flush_v, byte_v;
   srctok_pkg::tok_kind_type                 op_kind;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign b            = req_ch.byte_value;
   assign is_digit     = b >= srctok_pkg::ChDigit0 && b <= srctok_pkg::ChDigit9;
   assign is_alpha     = (b >= srctok_pkg::ChLowerA && b <= srctok_pkg::ChLowerZ) ||
                         (b >= srctok_pkg::ChUpperA && b <= srctok_pkg::ChUpperZ);
   assign extend       = (mode_ff == srctok_pkg::MODE_NUM && is_digit) ||
                         (mode_ff == srctok_pkg::MODE_ID && (is_digit || is_alpha));
   assign hit          = srctok_pkg::kw_lookup(kbuf_ff, run_ff);

   // Token for whatever run or '=' is pending
   always_comb begin
      unique case (mode_ff)
         srctok_pkg::MODE_EQ:
            flush_tok = srctok_pkg::mk_slot(srctok_pkg::TK_EQUAL, start_ff,
                                            srctok_pkg::TokLenW'(1), line_ff, 1'b0, '0);
         srctok_pkg::MODE_NUM:
            flush_tok = srctok_pkg::mk_slot(srctok_pkg::TK_NUMBER, start_ff,
                                            srctok_pkg::TokLenW'(run_ff), line_ff,
                                            1'b0, '0);
         srctok_pkg::MODE_ID:
            flush_tok = srctok_pkg::mk_slot(hit.kind, start_ff,
                                            srctok_pkg::TokLenW'(run_ff), line_ff,
                                            hit.bool_value, '0);
         default:
            flush_tok = '0;
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      run_in    = run_ff;
      kbuf_in   = kbuf_ff;
      line_in   = line_ff;
      flush_v   = 1'b0;
      byte_v    = 1'b0;
      byte_tok  = '0;
      op_kind   = srctok_pkg::TK_ERROR;

      if (accept) begin
         if (req_ch.kind == srctok_pkg::ItemEnd) begin
            // flush, mark end of file, return to reset state
            flush_v  = mode_ff != srctok_pkg::MODE_IDLE;
            byte_v   = 1'b1;
            byte_tok = srctok_pkg::mk_slot(srctok_pkg::TK_EOF, pos_ff, '0, line_ff,
                                           1'b0, '0);
            mode_in  = srctok_pkg::MODE_IDLE;
            pos_in   = '0;
            start_in = '0;
            run_in   = '0;
            kbuf_in  = '0;
            line_in  = srctok_pkg::TokLineW'(1);
         end else begin
            pos_in = pos_ff + 1'b1;
            if (mode_ff == srctok_pkg::MODE_EQ && b == srctok_pkg::ChEqual) begin
               byte_v   = 1'b1;
               byte_tok = srctok_pkg::mk_slot(srctok_pkg::TK_EQUAL_EQUAL, start_ff,
                                              srctok_pkg::TokLenW'(2), line_ff,
                                              1'b0, '0);
               mode_in  = srctok_pkg::MODE_IDLE;
            end else if (extend) begin
               if (mode_ff == srctok_pkg::MODE_ID &&
                   run_ff < srctok_pkg::LengthBits'(srctok_pkg::KwMaxLen)) begin
                  kbuf_in[8*run_ff[2:0] +: 8] = b;
               end
               if (run_ff < srctok_pkg::LenMax) begin
                  run_in = run_ff + 1'b1;
               end
            end else begin
               flush_v = mode_ff != srctok_pkg::MODE_IDLE;
               mode_in = srctok_pkg::MODE_IDLE;
               unique case (b)
                  srctok_pkg::ChPlus:   op_kind = srctok_pkg::TK_PLUS;
                  srctok_pkg::ChMinus:  op_kind = srctok_pkg::TK_MINUS;
                  srctok_pkg::ChStar:   op_kind = srctok_pkg::TK_STAR;
                  srctok_pkg::ChSlash:  op_kind = srctok_pkg::TK_SLASH;
                  srctok_pkg::ChLess:   op_kind = srctok_pkg::TK_LESS;
                  srctok_pkg::ChLParen: op_kind = srctok_pkg::TK_LPAREN;
                  srctok_pkg::ChRParen: op_kind = srctok_pkg::TK_RPAREN;
                  srctok_pkg::ChLBrace: op_kind = srctok_pkg::TK_LBRACE;
                  srctok_pkg::ChRBrace: op_kind = srctok_pkg::TK_RBRACE;
                  srctok_pkg::ChComma:  op_kind = srctok_pkg::TK_COMMA;
                  default:              op_kind = srctok_pkg::TK_ERROR;
               endcase
               priority if (op_kind != srctok_pkg::TK_ERROR) begin
                  byte_v   = 1'b1;
                  byte_tok = srctok_pkg::mk_slot(op_kind, pos_ff,
                                                 srctok_pkg::TokLenW'(1), line_ff,
                                                 1'b0, '0);
               end else if (b == srctok_pkg::ChEqual) begin
                  mode_in  = srctok_pkg::MODE_EQ;
                  start_in = pos_ff;
               end else if (b == srctok_pkg::ChSpace || b == srctok_pkg::ChTab ||
                            b == srctok_pkg::ChCr) begin
                  // skip
               end else if (b == srctok_pkg::ChLf) begin
                  line_in = line_ff + 1'b1;
               end else if (is_digit || is_alpha) begin
                  mode_in  = is_digit ? srctok_pkg::MODE_NUM : srctok_pkg::MODE_ID;
                  start_in = pos_ff;
                  run_in   = srctok_pkg::LengthBits'(1);
                  kbuf_in  = is_digit ? '0 : srctok_pkg::KwBufW'(b);
               end else begin
                  byte_v   = 1'b1;
                  byte_tok = srctok_pkg::mk_slot(srctok_pkg::TK_ERROR, pos_ff,
                                                 srctok_pkg::TokLenW'(1), line_ff,
                                                 1'b0, b);
               end
            end
         end
      end
   end

   // Pack the flush token first; a lone token always sits in the first slot
   always_comb begin
      q_wr.push         = accept && (flush_v || byte_v);
      q_wr.entry.first  = flush_v ? flush_tok : byte_tok;
      q_wr.entry.second = byte_tok;
      q_wr.entry.two    = flush_v && byte_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= srctok_pkg::MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         run_ff   <= '0;
         kbuf_ff  <= '0;
         line_ff  <= srctok_pkg::TokLineW'(1);
      end else begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         run_ff   <= run_in;
         kbuf_ff  <= kbuf_in;
         line_ff  <= line_in;
      end
   end

endmodule

// File: hdl/srctok_queue.sv
// ----------------------------------------------------------------------------
// srctok_queue
// Small first-in first-out buffer of token entries between front and back.
// ----------------------------------------------------------------------------
module srctok_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  srctok_pkg::q_wr_type  q_wr,
   output logic                  q_full,
   output srctok_pkg::q_rd_type  q_rd,
   input  logic                  q_pop
);

   srctok_pkg::q_entry_type              mem_ff [srctok_pkg::QueueDepth];
   logic [srctok_pkg::QPtrW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [srctok_pkg::QPtrW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [srctok_pkg::QCountW-1:0]       count_ff, count_in;
   logic                                 do_push, do_pop;

   assign q_full      = count_ff == srctok_pkg::QCountW'(srctok_pkg::QueueDepth);
   assign q_rd.valid  = count_ff != '0;
   assign q_rd.entry  = mem_ff[rd_ptr_ff];
   assign do_push     = q_wr.push && !q_full;
   assign do_pop      = q_pop && q_rd.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= q_wr.entry;
      end
   end

endmodule

// File: hdl/srctok_back.sv
// ----------------------------------------------------------------------------
// srctok_back
// Emitter: splits each queue entry into tokens and drives the token channel.
// ----------------------------------------------------------------------------
module srctok_back (
   input  logic                  clock,
   input  logic                  reset,
   input  srctok_pkg::q_rd_type  q_rd,
   output logic                  q_pop,
   srctok_rsp_if.source          rsp_ch
);

   logic                      out_valid_ff, out_valid_in;
   srctok_pkg::tok_slot_type  out_slot_ff, out_slot_in;
   logic                      out_last_ff, out_last_in;
   logic                      pend_valid_ff, pend_valid_in;
   srctok_pkg::tok_slot_type  pend_slot_ff, pend_slot_in;
   logic                      out_free;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign q_pop    = out_free && !pend_valid_ff && q_rd.valid;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_slot_in   = out_slot_ff;
      out_last_in   = out_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      if (out_free) begin
         priority if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_slot_in   = pend_slot_ff;
            out_last_in   = 1'b1;
            pend_valid_in = 1'b0;
         end else if (q_rd.valid) begin
            out_valid_in  = 1'b1;
            out_slot_in   = q_rd.entry.first;
            out_last_in   = !q_rd.entry.two;
            pend_valid_in = q_rd.entry.two;
            pend_slot_in  = q_rd.entry.second;
         end else begin
            out_valid_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_slot_ff  <= out_slot_in;
      out_last_ff  <= out_last_in;
      pend_slot_ff <= pend_slot_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.token_kind   = out_slot_ff.kind;
   assign rsp_ch.start_pos    = out_slot_ff.start;
   assign rsp_ch.token_length = out_slot_ff.length;
   assign rsp_ch.line_number  = out_slot_ff.line;
   assign rsp_ch.bool_value   = out_slot_ff.bool_value;
   assign rsp_ch.error_byte   = out_slot_ff.error_byte;
   assign rsp_ch.last         = out_last_ff;

endmodule

// File: hdl/source_tokenizer_top.sv
// ----------------------------------------------------------------------------
// source_tokenizer_top
// Streaming lexer: source bytes in, tokens (kind, offset, length, line) out.
// ----------------------------------------------------------------------------
//
//   channel  | dir | word                                   | accepted when
//   ---------+-----+----------------------------------------+------------------
//   req_ch   | in  | kind, byte_value                       | valid && ready
//   rsp_ch   | out | token_kind, start_pos, token_length,   | valid && ready
//            |     | line_number, bool_value, error_byte,   |
//            |     | last                                   |
//
// One source word is taken every cycle while the four-entry token queue has
// room; the scanner state settles within that cycle. Tokens leave at one per
// cycle while rsp_ch is not stalled, two-token words in turn; the first token
// of a word passes through the queue and the output register to rsp_ch.
// Synchronous reset clears scanner state, queue pointers and output valid
// flags. A stalled token channel fills the queue, then drops req_ch.ready.
//
module source_tokenizer_top (
   input  logic         clock,
   input  logic         reset,
   srctok_req_if.sink   req_ch,
   srctok_rsp_if.source rsp_ch
);

   // Front to queue: push with the tokens of one source word
   srctok_pkg::q_wr_type  q_wr;
   // Queue to back: head entry and its valid flag
   srctok_pkg::q_rd_type  q_rd;
   logic                  q_full;
   logic                  q_pop;

   // Classify bytes, hold pending runs, build tokens
   srctok_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .q_wr   (q_wr)
   );

   // Decouple scanning from emission
   srctok_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_full (q_full),
      .q_rd   (q_rd),
      .q_pop  (q_pop)
   );

   // Serialise entries onto the token channel, mark the last of each word
   srctok_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_rd   (q_rd),
      .q_pop  (q_pop),
      .rsp_ch (rsp_ch)
   );

endmodule
